/* hdl/blackbody_covariance_bin_integrator_defines.svh */
// Assertion macros for the blackbody bin integrator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BLACKBODY_COVARIANCE_BIN_INTEGRATOR_DEFINES_SVH
`define BLACKBODY_COVARIANCE_BIN_INTEGRATOR_DEFINES_SVH

// Check a property while out of reset
`define BBCI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define BBCI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bbci_pkg.sv */
// Shared types and constants for the blackbody bin integrator.
// No dependencies.
package bbci_pkg;

  localparam int ENERGY_FRAC_BITS = 24;

  localparam logic [63:0] ONE62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ONE58   = 64'h0400_0000_0000_0000;
  localparam logic [63:0] LN2_Q58 = 64'h02C5_C85F_DF47_3DE6;
  localparam logic [63:0] NORM_Q48 = 64'd48526285985;
  localparam logic [63:0] LIM_POS = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;
  localparam int X_LIMIT   = 48;
  localparam int EXP_TERMS = 20;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMPERATURE = 2'd0,
    CFG_SCALE_CONST = 2'd1,
    CFG_SCALE_LIN   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] energy_edge;
    logic        first_edge;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] bin_flux;
    logic               saturated;
  } out_word_t;

endpackage

/* hdl/blackbody_covariance_bin_integrator.sv */
// Blackbody bin integrator: Simpson's rule over energy bins, one shared
// 32x32 multiplier and one bit-serial divider under a sequencer.
// Depends on bbci_pkg and blackbody_covariance_bin_integrator_defines.svh.
//
// Usage:
//   in_*  : one word per bin edge (energy_edge, first_edge). in_ready is high
//           only while the sequencer is idle.
//   out_* : one word (bin_flux, saturated) per edge that closes a bin; an
//           edge marked first, or the first edge after reset, gives none.
//   cfg_* : register writes (index, data), always ready; write only while
//           idle. Index 3 is ignored.
// Work: a density evaluation is mostly the divider retiring one quotient bit a
//   cycle (e/kT, twenty series terms, x/(1-exp(-x))); zero energy or the
//   large-ratio cut-off ends it without the divider. A first edge takes one
//   evaluation, a closing edge two plus two multiplies. One edge at a time; the
//   next is taken once idle, even while the last result still waits in the
//   output register.
// Reset (rst_n low, synchronous): registers to defaults, edge history cleared.
// Stall: if out_ready is low when a new result is done, the sequencer holds
//   in its final step until the output register frees.
`include "blackbody_covariance_bin_integrator_defines.svh"

module blackbody_covariance_bin_integrator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bbci_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbci_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_D_START, ST_X, ST_RED, ST_N, ST_T_MUL, ST_T_DIV, ST_T_ACC,
    ST_SHIFT, ST_D, ST_Q, ST_H1, ST_H1C, ST_H2C, ST_BIG, ST_P0, ST_P1,
    ST_DCLIP, ST_D_DONE, ST_M1, ST_FLUX, ST_MUL, ST_MFIN, ST_DIV
  } state_t;

  localparam int SMALL_SH = 38 - bbci_pkg::ENERGY_FRAC_BITS;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] kt_r, s0_r, s1_r;
  logic [31:0] e2_r, e2_nxt, cur_e_r, cur_e_nxt, prev_edge_r, prev_edge_nxt;
  logic        first_r, first_nxt, which_r, which_nxt, flag_r, flag_nxt;
  logic        have_r, have_nxt, ineg_r, ineg_nxt, fneg_r, fneg_nxt;
  logic [63:0] x_r, x_nxt, sum_r, sum_nxt, term_r, term_nxt, r62_r, r62_nxt;
  logic [63:0] u_r, u_nxt, q_r, q_nxt, h1_r, h1_nxt, h2_r, h2_nxt;
  logic [63:0] p0_r, p0_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [4:0]  kk_r, kk_nxt;
  logic [47:0] f2_r, f2_nxt, dens_r, dens_nxt, prev_dens_r, prev_dens_nxt;
  logic [50:0] msum_r, msum_nxt;
  // multiply unit
  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt, res_r, res_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;
  logic [6:0]   sh_r, sh_nxt;
  // divide unit
  logic [63:0] dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic        dovf_r, dovf_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  // output register
  logic                 out_valid_r, out_valid_nxt;
  bbci_pkg::out_word_t  out_data_r, out_data_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and datapath next values
  always_comb begin
    logic [31:0]  ah, bh, abs0, abs1;
    logic [63:0]  pp, quo_sat, p1, inner, mag, lncand;
    logic [127:0] shifted;
    logic [64:0]  rem2;
    logic [37:0]  xlim;
    logic [32:0]  esum, de, mde;
    logic [50:0]  sum51;
    logic         bad0;

    state_nxt = state_r;   ret_nxt = ret_r;
    e2_nxt = e2_r;         cur_e_nxt = cur_e_r;   prev_edge_nxt = prev_edge_r;
    first_nxt = first_r;   which_nxt = which_r;   flag_nxt = flag_r;
    have_nxt = have_r;     ineg_nxt = ineg_r;     fneg_nxt = fneg_r;
    x_nxt = x_r;  sum_nxt = sum_r;  term_nxt = term_r;  r62_nxt = r62_r;
    u_nxt = u_r;  q_nxt = q_r;  h1_nxt = h1_r;  h2_nxt = h2_r;  p0_nxt = p0_r;
    n_nxt = n_r;  kk_nxt = kk_r;
    f2_nxt = f2_r;  dens_nxt = dens_r;  prev_dens_nxt = prev_dens_r;
    msum_nxt = msum_r;
    ma_nxt = ma_r;  mb_nxt = mb_r;  res_nxt = res_r;  acc_nxt = acc_r;
    mcnt_nxt = mcnt_r;  sh_nxt = sh_r;
    dvd_nxt = dvd_r;  dvs_nxt = dvs_r;  rem_nxt = rem_r;  quo_nxt = quo_r;
    dovf_nxt = dovf_r;  dcnt_nxt = dcnt_r;
    out_valid_nxt = out_valid_r;  out_data_nxt = out_data_r;

    abs0 = s0_r[31] ? (~s0_r + 32'd1) : s0_r;
    abs1 = s1_r[31] ? (~s1_r + 32'd1) : s1_r;
    quo_sat = dovf_r ? {64{1'b1}} : quo_r;
    ah = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    bh = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = ah * bh;
    shifted = acc_r >> sh_r;
    rem2 = {rem_r, dvd_r[63]};
    lncand = bbci_pkg::LN2_Q58 << dcnt_r[2:0];
    xlim = 38'(kt_r) * 38'(bbci_pkg::X_LIMIT);
    esum = {1'b0, prev_edge_r} + {1'b0, e2_r};
    de = {1'b0, e2_r} - {1'b0, prev_edge_r};
    mde = de[32] ? (~de + 33'd1) : de;
    sum51 = {{3{prev_dens_r[47]}}, prev_dens_r} + {{1{dens_r[47]}}, dens_r, 2'b00}
          + {{3{f2_r[47]}}, f2_r};
    p1 = s1_r[31] ? (~res_r + 64'd1) : res_r;
    inner = p0_r + p1;
    mag = inner[63] ? (~inner + 64'd1) : inner;
    bad0 = (prev_edge_r == 32'd0) || (prev_dens_r == bbci_pkg::LIM_POS[47:0])
        || (prev_dens_r == bbci_pkg::LIM_NEG[47:0]);

    // Free the output register when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          e2_nxt = in_data.energy_edge;
          first_nxt = in_data.first_edge;
          cur_e_nxt = in_data.energy_edge;
          which_nxt = 1'b0;
          flag_nxt = 1'b0;
          state_nxt = ST_D_START;
        end
      end
      // Density: special cases, then x = e/kT in Q6.58
      ST_D_START: begin
        if (cur_e_r == 32'd0 || kt_r == 32'd0) begin
          flag_nxt = 1'b1;
          dens_nxt = '0;
          state_nxt = ST_D_DONE;
        end else if ({6'd0, cur_e_r} >= xlim) begin
          dens_nxt = '0;
          state_nxt = ST_D_DONE;
        end else begin
          dvd_nxt = {32'd0, cur_e_r};  dvs_nxt = {32'd0, kt_r};
          rem_nxt = '0;  quo_nxt = '0;  dovf_nxt = 1'b0;
          dcnt_nxt = 7'd121;  ret_nxt = ST_X;  state_nxt = ST_DIV;
        end
      end
      // Range reduction by ln2: x stays below 48, so n fits in seven bits
      ST_X: begin
        x_nxt = quo_sat;
        rem_nxt = quo_sat;  quo_nxt = '0;
        dcnt_nxt = 7'd6;  state_nxt = ST_RED;
      end
      // Compare and subtract ln2 scaled by 64 down to 1
      ST_RED: begin
        if (rem_r >= lncand) begin
          rem_nxt = rem_r - lncand;
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        if (dcnt_r == 7'd0) begin
          state_nxt = ST_N;
        end else begin
          dcnt_nxt = dcnt_r - 7'd1;
        end
      end
      ST_N: begin
        if (quo_r > 64'd62) begin
          u_nxt = '0;
          state_nxt = ST_D;
        end else begin
          n_nxt = quo_r[5:0];
          r62_nxt = {rem_r[59:0], 4'd0};
          sum_nxt = bbci_pkg::ONE62;
          term_nxt = bbci_pkg::ONE62;
          kk_nxt = 5'd1;
          state_nxt = ST_T_MUL;
        end
      end
      // Taylor series of exp(-r)
      ST_T_MUL: begin
        ma_nxt = term_r;  mb_nxt = r62_r;  sh_nxt = 7'd62;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_T_DIV;  state_nxt = ST_MUL;
      end
      ST_T_DIV: begin
        dvd_nxt = res_r;  dvs_nxt = {59'd0, kk_r};
        rem_nxt = '0;  quo_nxt = '0;  dovf_nxt = 1'b0;
        dcnt_nxt = 7'd63;  ret_nxt = ST_T_ACC;  state_nxt = ST_DIV;
      end
      ST_T_ACC: begin
        term_nxt = quo_r;
        sum_nxt = kk_r[0] ? (sum_r - quo_r) : (sum_r + quo_r);
        if (kk_r == 5'(bbci_pkg::EXP_TERMS)) begin
          state_nxt = ST_SHIFT;
        end else begin
          kk_nxt = kk_r + 5'd1;
          state_nxt = ST_T_MUL;
        end
      end
      ST_SHIFT: begin
        u_nxt = sum_r >> n_r;
        state_nxt = ST_D;
      end
      // q = x / (1 - exp(-x))
      ST_D: begin
        if (u_r == bbci_pkg::ONE62) begin
          q_nxt = bbci_pkg::ONE58;
          state_nxt = ST_H1;
        end else begin
          dvd_nxt = x_r;  dvs_nxt = bbci_pkg::ONE62 - u_r;
          rem_nxt = '0;  quo_nxt = '0;  dovf_nxt = 1'b0;
          dcnt_nxt = 7'd125;  ret_nxt = ST_Q;  state_nxt = ST_DIV;
        end
      end
      ST_Q: begin
        q_nxt = quo_sat;
        state_nxt = ST_H1;
      end
      ST_H1: begin
        ma_nxt = u_r;  mb_nxt = q_r;  sh_nxt = 7'd58;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_H1C;  state_nxt = ST_MUL;
      end
      ST_H1C: begin
        h1_nxt = (res_r > bbci_pkg::ONE62) ? bbci_pkg::ONE62 : res_r;
        ma_nxt = h1_nxt;  mb_nxt = q_r;  sh_nxt = 7'd58;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_H2C;  state_nxt = ST_MUL;
      end
      ST_H2C: begin
        h2_nxt = (res_r > bbci_pkg::ONE62) ? bbci_pkg::ONE62 : res_r;
        ma_nxt = {32'd0, kt_r};  mb_nxt = h1_r;  sh_nxt = 7'd38;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_BIG;  state_nxt = ST_MUL;
      end
      // Weighted terms
      ST_BIG: begin
        ma_nxt = res_r;  mb_nxt = {32'd0, abs0};  sh_nxt = 7'd30;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_P0;  state_nxt = ST_MUL;
      end
      ST_P0: begin
        p0_nxt = s0_r[31] ? (~res_r + 64'd1) : res_r;
        ma_nxt = h2_r >> SMALL_SH;  mb_nxt = {32'd0, abs1};  sh_nxt = 7'd30;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_P1;  state_nxt = ST_MUL;
      end
      ST_P1: begin
        ineg_nxt = inner[63];
        ma_nxt = {32'd0, cur_e_r};  mb_nxt = mag;
        sh_nxt = 7'(2 * bbci_pkg::ENERGY_FRAC_BITS);
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_DCLIP;  state_nxt = ST_MUL;
      end
      ST_DCLIP: begin
        if (ineg_r) begin
          if (res_r > bbci_pkg::LIM_NEG) begin
            flag_nxt = 1'b1;
            dens_nxt = bbci_pkg::LIM_NEG[47:0];
          end else begin
            dens_nxt = 48'(~res_r + 64'd1);
          end
        end else if (res_r > bbci_pkg::LIM_POS) begin
          flag_nxt = 1'b1;
          dens_nxt = bbci_pkg::LIM_POS[47:0];
        end else begin
          dens_nxt = res_r[47:0];
        end
        state_nxt = ST_D_DONE;
      end
      // Route the density: end of bin first, then the midpoint
      ST_D_DONE: begin
        if (!which_r) begin
          f2_nxt = dens_r;
          if (first_r || !have_r) begin
            prev_edge_nxt = e2_r;
            prev_dens_nxt = dens_r;
            have_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if (bad0) begin
              flag_nxt = 1'b1;
            end
            cur_e_nxt = esum[32:1];
            which_nxt = 1'b1;
            state_nxt = ST_D_START;
          end
        end else begin
          msum_nxt = sum51[50] ? (~sum51 + 51'd1) : sum51;
          fneg_nxt = de[32] != sum51[50];
          ma_nxt = {31'd0, mde};  mb_nxt = bbci_pkg::NORM_Q48;
          sh_nxt = 7'(bbci_pkg::ENERGY_FRAC_BITS);
          acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_M1;  state_nxt = ST_MUL;
        end
      end
      ST_M1: begin
        ma_nxt = res_r;  mb_nxt = {13'd0, msum_r};  sh_nxt = 7'd40;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = ST_FLUX;  state_nxt = ST_MUL;
      end
      // Clip, load the output register, and advance the edge history
      ST_FLUX: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.saturated = flag_r;
          if (fneg_r) begin
            if (res_r > bbci_pkg::LIM_NEG) begin
              out_data_nxt.saturated = 1'b1;
              out_data_nxt.bin_flux = bbci_pkg::LIM_NEG[47:0];
            end else begin
              out_data_nxt.bin_flux = 48'(~res_r + 64'd1);
            end
          end else if (res_r > bbci_pkg::LIM_POS) begin
            out_data_nxt.saturated = 1'b1;
            out_data_nxt.bin_flux = bbci_pkg::LIM_POS[47:0];
          end else begin
            out_data_nxt.bin_flux = res_r[47:0];
          end
          prev_edge_nxt = e2_r;
          prev_dens_nxt = f2_r;
          state_nxt = ST_IDLE;
        end
      end
      // Shared multiplier: four 32x32 partial products
      ST_MUL: begin
        case (mcnt_r)
          2'd0:    acc_nxt = acc_r + {64'd0, pp};
          2'd3:    acc_nxt = acc_r + {pp, 64'd0};
          default: acc_nxt = acc_r + {32'd0, pp, 32'd0};
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          state_nxt = ST_MFIN;
        end
      end
      ST_MFIN: begin
        res_nxt = (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];
        state_nxt = ret_r;
      end
      // Shared divider: one quotient bit per cycle
      ST_DIV: begin
        if (rem2 >= {1'b0, dvs_r}) begin
          rem_nxt = 64'(rem2 - {1'b0, dvs_r});
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem2[63:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        dovf_nxt = dovf_r | quo_r[63];
        dvd_nxt = {dvd_r[62:0], 1'b0};
        if (dcnt_r == 7'd0) begin
          state_nxt = ret_r;
        end else begin
          dcnt_nxt = dcnt_r - 7'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      have_r <= 1'b0;
      prev_edge_r <= '0;
      prev_dens_r <= '0;
      kt_r <= 32'd16777216;
      s0_r <= 32'd1073741824;
      s1_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      have_r <= have_nxt;
      prev_edge_r <= prev_edge_nxt;
      prev_dens_r <= prev_dens_nxt;
      if (cfg_valid) begin
        case (bbci_pkg::cfg_idx_t'(cfg_index))
          bbci_pkg::CFG_TEMPERATURE: kt_r <= cfg_data;
          bbci_pkg::CFG_SCALE_CONST: s0_r <= cfg_data;
          bbci_pkg::CFG_SCALE_LIN:   s1_r <= cfg_data;
          default: ;
        endcase
      end
    end
    e2_r <= e2_nxt;  cur_e_r <= cur_e_nxt;  first_r <= first_nxt;
    which_r <= which_nxt;  flag_r <= flag_nxt;  ineg_r <= ineg_nxt;
    fneg_r <= fneg_nxt;  x_r <= x_nxt;  sum_r <= sum_nxt;  term_r <= term_nxt;
    r62_r <= r62_nxt;  u_r <= u_nxt;  q_r <= q_nxt;  h1_r <= h1_nxt;
    h2_r <= h2_nxt;  p0_r <= p0_nxt;  n_r <= n_nxt;  kk_r <= kk_nxt;
    f2_r <= f2_nxt;  dens_r <= dens_nxt;  msum_r <= msum_nxt;
    ma_r <= ma_nxt;  mb_r <= mb_nxt;  res_r <= res_nxt;  acc_r <= acc_nxt;
    mcnt_r <= mcnt_nxt;  sh_r <= sh_nxt;
    dvd_r <= dvd_nxt;  dvs_r <= dvs_nxt;  rem_r <= rem_nxt;  quo_r <= quo_nxt;
    dovf_r <= dovf_nxt;  dcnt_r <= dcnt_nxt;
    out_data_r <= out_data_nxt;
  end

  `BBCI_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted word did not start work")
  `BBCI_ASSERT(a_result_from_flux, $rose(out_valid) |-> $past(state_r == ST_FLUX), "result raised outside final step")
  `BBCI_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result pending after reset")

endmodule
